[design/lrs_pkg.sv]
// Package for the lane row run edge scanner.
// Holds field widths, frame limits and configuration register indexes.
// No dependencies; lrs_row_if and all modules import it.
`default_nettype none

package lrs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = 10;
  localparam int ROW_W  = 10;
  localparam int DIM_W  = 11;
  localparam int KEPT_W = 2;
  localparam logic [KEPT_W-1:0] KEPT_SAT = KEPT_W'(2);

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_SCAN_START_ROW = 3'd2,
    REG_MIN_RUN_WIDTH  = 3'd3,
    REG_MIN_LANE_WIDTH = 3'd4
  } reg_index_t;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST    = DIM_W'(640);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST   = DIM_W'(480);
  localparam logic [ROW_W-1:0] SCAN_START_ROW_RST = ROW_W'(240);
  localparam logic [DIM_W-1:0] MIN_RUN_WIDTH_RST  = DIM_W'(2);
  localparam logic [DIM_W-1:0] MIN_LANE_WIDTH_RST = DIM_W'(20);

endpackage

`default_nettype wire

[design/lrs_ifs.sv]
// Valid/ready channel interfaces of the lane row run edge scanner.
// lrs_pixel_if carries mask pixels, lrs_row_if carries per-row results.
// Depends on lrs_pkg.
`default_nettype none

interface lrs_pixel_if;
  logic valid;
  logic ready;
  logic pixel;
  logic frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface lrs_row_if;
  import lrs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] left_edge;
  logic [COL_W-1:0] right_edge;
  logic             lane_found;
  logic             last_row;

  modport source (output valid, output row_index, output left_edge, output right_edge,
                  output lane_found, output last_row, input ready);
  modport sink   (input valid, input row_index, input left_edge, input right_edge,
                  input lane_found, input last_row, output ready);
endinterface

`default_nettype wire

[design/lane_row_run_edge_scanner_unit.sv]
// Lane row run edge scanner top level: pixel input register, run tracking, row result register.
// Depends on lrs_pkg and the channel interfaces in lrs_ifs.sv.
//
// The block takes one mask pixel per clock unless a row result stalls it.
// Each pixel is held in an input register and then updates the column,
// row and run state; that update loop sets the rate. A row result enters
// the output register as the row's last pixel leaves the input register.
// While the output register is empty or being emptied, pixels keep
// flowing; while a result waits there unaccepted, the pixel in the input
// register holds and the input stalls. The user must write configuration
// through the APB port while no pixel is in flight; the block does not
// enforce it. Width and height are saturated to 1..1024.
`default_nettype none

module lane_row_run_edge_scanner_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  lrs_pixel_if.sink                         pixels,
  lrs_row_if.source                         rows,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lrs_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [lrs_pkg::DATA_W-1:0]   pwdata,
  output logic      [lrs_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lrs_pkg::*;

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [ROW_W-1:0] scan_start_row;
  logic [DIM_W-1:0] min_run_width;
  logic [DIM_W-1:0] min_lane_width;

  logic             in_valid;
  logic             in_pixel;
  logic             in_frame_start;

  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic              inside_run;
  logic [COL_W-1:0]  run_begin;
  logic [KEPT_W-1:0] kept_runs;
  logic [COL_W-1:0]  first_left;
  logic [COL_W-1:0]  last_right;

  logic             out_valid;
  logic [ROW_W-1:0] out_row_index;
  logic [COL_W-1:0] out_left_edge;
  logic [COL_W-1:0] out_right_edge;
  logic             out_lane_found;
  logic             out_last_row;

  reg_index_t       wr_index;
  logic             cfg_write;
  logic             advance;

  logic [DIM_W-1:0]  width_eff;
  logic [DIM_W-1:0]  height_eff;
  logic [COL_W-1:0]  col_e;
  logic [ROW_W-1:0]  row_e;
  logic              inside_e;
  logic [COL_W-1:0]  begin_e;
  logic [KEPT_W-1:0] kept_e;
  logic [COL_W-1:0]  first_e;
  logic [COL_W-1:0]  last_e;
  logic              active;
  logic              row_end;
  logic              last_row_c;
  logic [COL_W-1:0]  begin_c;
  logic [COL_W-1:0]  end_col;
  logic              close_c;
  logic [DIM_W-1:0]  run_len;
  logic              keep;
  logic [COL_W-1:0]  span;
  logic              lane_c;

  logic              inside_run_next;
  logic [COL_W-1:0]  run_begin_next;
  logic [KEPT_W-1:0] kept_runs_next;
  logic [COL_W-1:0]  first_left_next;
  logic [COL_W-1:0]  last_right_next;

  // Configuration port
  assign pready    = 1'b1;
  assign wr_index  = reg_index_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= FRAME_WIDTH_RST;
      frame_height   <= FRAME_HEIGHT_RST;
      scan_start_row <= SCAN_START_ROW_RST;
      min_run_width  <= MIN_RUN_WIDTH_RST;
      min_lane_width <= MIN_LANE_WIDTH_RST;
    end else if (cfg_write) begin
      case (wr_index)
        REG_FRAME_WIDTH:    frame_width    <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= pwdata[DIM_W-1:0];
        REG_SCAN_START_ROW: scan_start_row <= pwdata[ROW_W-1:0];
        REG_MIN_RUN_WIDTH:  min_run_width  <= pwdata[DIM_W-1:0];
        REG_MIN_LANE_WIDTH: min_lane_width <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (wr_index)
      REG_FRAME_WIDTH:    prdata = DATA_W'(frame_width);
      REG_FRAME_HEIGHT:   prdata = DATA_W'(frame_height);
      REG_SCAN_START_ROW: prdata = DATA_W'(scan_start_row);
      REG_MIN_RUN_WIDTH:  prdata = DATA_W'(min_run_width);
      REG_MIN_LANE_WIDTH: prdata = DATA_W'(min_lane_width);
      default:            prdata = '0;
    endcase
  end

  // Input register
  assign advance      = in_valid && (!out_valid || rows.ready);
  assign pixels.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixels.ready) begin
      in_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixels.valid && pixels.ready) begin
      in_pixel       <= pixels.pixel;
      in_frame_start <= pixels.frame_start;
    end
  end

  // Run tracking
  always_comb begin
    if (frame_width == '0) begin
      width_eff = DIM_W'(1);
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      width_eff = DIM_W'(MAX_WIDTH);
    end else begin
      width_eff = frame_width;
    end
    if (frame_height == '0) begin
      height_eff = DIM_W'(1);
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      height_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  always_comb begin
    col_e    = in_frame_start ? '0 : column_count;
    row_e    = in_frame_start ? '0 : row_count;
    inside_e = in_frame_start ? 1'b0 : inside_run;
    begin_e  = in_frame_start ? '0 : run_begin;
    kept_e   = in_frame_start ? '0 : kept_runs;
    first_e  = in_frame_start ? '0 : first_left;
    last_e   = in_frame_start ? '0 : last_right;

    active     = row_e >= scan_start_row;
    row_end    = ({1'b0, col_e} + DIM_W'(1)) >= width_eff;
    last_row_c = ({1'b0, row_e} + DIM_W'(1)) >= height_eff;

    begin_c = inside_e ? begin_e : col_e;
    end_col = in_pixel ? col_e : col_e - COL_W'(1);
    close_c = active && (in_pixel ? row_end : inside_e);
    run_len = {1'b0, end_col} - {1'b0, begin_c} + DIM_W'(1);
    keep    = close_c && (end_col >= begin_c) && (run_len >= min_run_width);

    kept_runs_next  = (keep && kept_e < KEPT_SAT) ? kept_e + KEPT_W'(1) : kept_e;
    first_left_next = (keep && kept_e == '0) ? begin_c : first_e;
    last_right_next = keep ? end_col : last_e;
    inside_run_next = active ? in_pixel : inside_e;
    run_begin_next  = (active && in_pixel && !inside_e) ? col_e : begin_e;

    span   = last_right_next - first_left_next;
    lane_c = (kept_runs_next >= KEPT_SAT) && (last_right_next >= first_left_next) &&
             ({1'b0, span} >= min_lane_width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      inside_run   <= 1'b0;
      run_begin    <= '0;
      kept_runs    <= '0;
      first_left   <= '0;
      last_right   <= '0;
    end else if (advance) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= last_row_c ? '0 : row_e + ROW_W'(1);
        inside_run   <= 1'b0;
        run_begin    <= '0;
        kept_runs    <= '0;
        first_left   <= '0;
        last_right   <= '0;
      end else begin
        column_count <= col_e + COL_W'(1);
        row_count    <= row_e;
        inside_run   <= inside_run_next;
        run_begin    <= run_begin_next;
        kept_runs    <= kept_runs_next;
        first_left   <= first_left_next;
        last_right   <= last_right_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && active && row_end) begin
      out_valid <= 1'b1;
    end else if (rows.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && active && row_end) begin
      out_row_index  <= row_e;
      out_left_edge  <= first_left_next;
      out_right_edge <= last_right_next;
      out_lane_found <= lane_c;
      out_last_row   <= last_row_c;
    end
  end

  assign rows.valid      = out_valid;
  assign rows.row_index  = out_row_index;
  assign rows.left_edge  = out_left_edge;
  assign rows.right_edge = out_right_edge;
  assign rows.lane_found = out_lane_found;
  assign rows.last_row   = out_last_row;

endmodule

`default_nettype wire

[design/lrs_checker.sv]
// Port-level checks for the lane row run edge scanner result channel.
// Bound to lane_row_run_edge_scanner_unit; depends on lrs_pkg.
`default_nettype none

module lrs_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [lrs_pkg::ROW_W-1:0]   out_row_index,
  input wire logic [lrs_pkg::COL_W-1:0]   out_left_edge,
  input wire logic [lrs_pkg::COL_W-1:0]   out_right_edge,
  input wire logic                        out_lane_found
);
  import lrs_pkg::*;

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index) &&
      $stable(out_left_edge) && $stable(out_right_edge) && $stable(out_lane_found))
    else $error("stalled row item changed");

  a_edges_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_left_edge <= out_right_edge)
    else $error("left edge beyond right edge");

  a_lane_two_runs: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_lane_found |-> out_right_edge > out_left_edge + COL_W'(1))
    else $error("lane found without two separate runs");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("row item valid right after reset");

endmodule

bind lane_row_run_edge_scanner_unit lrs_checker u_lrs_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (rows.valid),
  .out_ready      (rows.ready),
  .out_row_index  (rows.row_index),
  .out_left_edge  (rows.left_edge),
  .out_right_edge (rows.right_edge),
  .out_lane_found (rows.lane_found)
);

`default_nettype wire

[verif/testbench.sv]
// Testbench for lane_row_run_edge_scanner_unit: directed and random mask pixel streams,
// each row result checked against a behavioral row-edge tracker held in a small class.
// Depends on lrs_pkg, the channel interfaces in lrs_ifs.sv and the scanner design files.

module testbench;
  import lrs_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 16;
  localparam int MAX_REPORTS  = 10;

  localparam logic [0:24] DIRECTED_MASK = 25'b1111111101111001101010000;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] left_edge;
    logic [COL_W-1:0] right_edge;
    logic             lane_found;
    logic             last_row;
  } row_result_t;

  class lane_row_tracker;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [ROW_W-1:0]  roi_reg;
    logic [DIM_W-1:0]  min_run_reg;
    logic [DIM_W-1:0]  min_lane_reg;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              in_run;
    logic [COL_W-1:0]  run_start;
    logic [KEPT_W-1:0] kept;
    logic [COL_W-1:0]  left;
    logic [COL_W-1:0]  right;
    row_result_t       pending_rows[$];
    int                errors;

    function new();
      width_reg    = FRAME_WIDTH_RST;
      height_reg   = FRAME_HEIGHT_RST;
      roi_reg      = SCAN_START_ROW_RST;
      min_run_reg  = MIN_RUN_WIDTH_RST;
      min_lane_reg = MIN_LANE_WIDTH_RST;
      col          = '0;
      row          = '0;
      errors       = 0;
      clear_row();
    endfunction

    function void set_reg(reg_index_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_FRAME_WIDTH:    width_reg    = value[DIM_W-1:0];
        REG_FRAME_HEIGHT:   height_reg   = value[DIM_W-1:0];
        REG_SCAN_START_ROW: roi_reg      = value[ROW_W-1:0];
        REG_MIN_RUN_WIDTH:  min_run_reg  = value[DIM_W-1:0];
        REG_MIN_LANE_WIDTH: min_lane_reg = value[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void clear_row();
      in_run    = 1'b0;
      run_start = '0;
      kept      = '0;
      left      = '0;
      right     = '0;
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return 32'(v);
    endfunction

    function void close_run(int unsigned end_col);
      int unsigned len;
      len = end_col - run_start + 1;
      in_run = 1'b0;
      if (end_col < run_start) return;
      if (len >= min_run_reg) begin
        if (kept == 0) left = run_start;
        right = end_col[COL_W-1:0];
        if (kept < KEPT_SAT) kept = kept + 1'b1;
      end
    endfunction

    function void take_pixel(logic p, logic fs);
      int unsigned w;
      int unsigned h;
      int unsigned span;
      logic        row_end;
      logic        lane;
      row_result_t res;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      if (fs) begin
        col = '0;
        row = '0;
        clear_row();
      end
      row_end = (32'(col) + 1 >= w);
      if (row >= roi_reg) begin
        if (p) begin
          if (!in_run) begin
            in_run    = 1'b1;
            run_start = col;
          end
        end else if (in_run) begin
          close_run(32'(col) - 1);
        end
        if (row_end) begin
          if (in_run) close_run(32'(col));
          span = 32'(right) - 32'(left);
          lane = (kept >= KEPT_SAT) && (right >= left) && (span >= min_lane_reg);
          res.row_index  = row;
          res.left_edge  = left;
          res.right_edge = right;
          res.lane_found = lane;
          res.last_row   = (32'(row) + 1 >= h);
          pending_rows   = {pending_rows, res};
        end
      end
      if (row_end) begin
        clear_row();
        col = '0;
        row = (32'(row) + 1 >= h) ? '0 : row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
    endfunction

    function void check_row(row_result_t got);
      row_result_t want;
      if (pending_rows.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected row result: row %0d left %0d right %0d lane %0b last %0b",
                   got.row_index, got.left_edge, got.right_edge, got.lane_found,
                   got.last_row);
        return;
      end
      want = pending_rows.pop_front();
      if (got.row_index !== want.row_index || got.left_edge !== want.left_edge ||
          got.right_edge !== want.right_edge || got.lane_found !== want.lane_found ||
          got.last_row !== want.last_row) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"row mismatch: expected row %0d left %0d right %0d lane %0b last %0b,",
                    " got row %0d left %0d right %0d lane %0b last %0b"},
                   want.row_index, want.left_edge, want.right_edge, want.lane_found,
                   want.last_row, got.row_index, got.left_edge, got.right_edge,
                   got.lane_found, got.last_row);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lrs_pixel_if pix_ch();
  lrs_row_if   row_ch();

  lane_row_run_edge_scanner_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .rows    (row_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lane_row_tracker tracker;
  bit hold_req;
  bit gaps_on;
  bit stalls_on;
  bit run_val;
  int run_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [DATA_W-1:0] high_junk(int field_w);
    return ($urandom_range(0, 3) == 0) ? ($urandom() << field_w) : '0;
  endfunction

  function automatic logic next_mask_bit(bit noisy);
    int hi;
    if (noisy) return 1'($urandom_range(0, 1));
    if (run_left == 0) begin
      run_val = !run_val;
      hi = (tracker.min_run_reg > 20) ? 40 : 2 * tracker.min_run_reg + 2;
      run_left = run_val ? $urandom_range(1, hi) : $urandom_range(1, 6);
    end
    run_left--;
    return run_val;
  endfunction

  task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic p, input logic fs);
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= p;
    pix_ch.frame_start <= fs;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    tracker.take_pixel(p, fs);
  endtask

  task automatic pixel_gap();
    int n;
    if (!gaps_on || $urandom_range(0, 9) < 7) return;
    n = idle_len();
    pix_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (tracker.pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input bit noisy);
    logic fs;
    for (int i = 0; i < n_items; i++) begin
      fs = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 199) == 0);
      send_pixel(next_mask_bit(noisy), fs);
      pixel_gap();
    end
  endtask

  task automatic pick_settings(input bit all_regs);
    logic [DATA_W-1:0] v;
    if (all_regs || $urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 11))
        0:       v = 0;
        1:       v = 1;
        2:       v = 2;
        3:       v = 2047;
        4:       v = 1024;
        default: v = $urandom_range(3, 40);
      endcase
      write_reg(REG_FRAME_WIDTH, v | high_junk(DIM_W));
    end
    if (all_regs || $urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 9))
        0:       v = 0;
        1:       v = 1;
        2:       v = 1030;
        default: v = $urandom_range(2, 12);
      endcase
      write_reg(REG_FRAME_HEIGHT, v | high_junk(DIM_W));
    end
    if (all_regs || $urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 9))
        0:       v = 1023;
        1:       v = tracker.height_reg + $urandom_range(0, 5);
        default: v = $urandom_range(0, 3);
      endcase
      write_reg(REG_SCAN_START_ROW, v | high_junk(ROW_W));
    end
    if (all_regs || $urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 11))
        0:       v = 0;
        1:       v = 1;
        2:       v = 2047;
        3:       v = 1024;
        default: v = $urandom_range(1, 6);
      endcase
      write_reg(REG_MIN_RUN_WIDTH, v | high_junk(DIM_W));
    end
    if (all_regs || $urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 9))
        0:       v = 0;
        1:       v = 2047;
        2:       v = 1;
        default: v = $urandom_range(1, 30);
      endcase
      write_reg(REG_MIN_LANE_WIDTH, v | high_junk(DIM_W));
    end
  endtask

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (pix_ch.valid && pix_ch.ready) || (row_ch.valid && row_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : row_sink
    int          stall;
    row_result_t got;
    stall = 0;
    row_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (row_ch.valid && row_ch.ready) begin
        got.row_index  = row_ch.row_index;
        got.left_edge  = row_ch.left_edge;
        got.right_edge = row_ch.right_edge;
        got.lane_found = row_ch.lane_found;
        got.last_row   = row_ch.last_row;
        tracker.check_row(got);
      end
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (stall == 0 && stalls_on && $urandom_range(0, 9) >= 7) begin
        stall = idle_len();
      end
      if (stall > 0) begin
        row_ch.ready <= 1'b0;
        stall--;
      end else begin
        row_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int n_items;
    tracker   = new();
    hold_req  = 1'b0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    run_val   = 1'b0;
    run_left  = 0;
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    pix_ch.valid       <= 1'b0;
    pix_ch.pixel       <= 1'b0;
    pix_ch.frame_start <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // six-pixel rows: ignored row, two runs with lane, one kept run, no kept run
    write_reg(REG_FRAME_WIDTH, 6);
    write_reg(REG_FRAME_HEIGHT, 4);
    write_reg(REG_SCAN_START_ROW, 1);
    write_reg(REG_MIN_RUN_WIDTH, 2);
    write_reg(REG_MIN_LANE_WIDTH, 3);
    for (int i = 0; i < 25; i++) begin
      send_pixel(DIRECTED_MASK[i], (i == 0) || (i == 24));
      pixel_gap();
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      pick_settings(ph == 0);
      gaps_on   = ($urandom_range(0, 4) != 0);
      stalls_on = ($urandom_range(0, 4) != 0);
      n_items   = $urandom_range(15, 35);
      if (ph == 3) begin
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_SCAN_START_ROW, 0);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end
      if (ph == 6) begin
        run_phase(n_items / 2, 1'b0);
        settle();
        run_phase(n_items - n_items / 2, 1'b0);
      end else begin
        run_phase(n_items, $urandom_range(0, 3) == 0);
      end
    end

    // full-width row with edges at both ends of the line
    settle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_reg(REG_FRAME_WIDTH, 2047);
    write_reg(REG_FRAME_HEIGHT, 2047);
    write_reg(REG_SCAN_START_ROW, 0);
    write_reg(REG_MIN_RUN_WIDTH, 3);
    write_reg(REG_MIN_LANE_WIDTH, 1000);
    for (int c = 0; c < MAX_WIDTH; c++) begin
      send_pixel((c < 10) || (c >= 1000), c == 0);
      pixel_gap();
    end

    settle();
    if (tracker.errors == 0 && tracker.pending_rows.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
